// ===== rtl/core/ahd_pkg.sv =====
package ahd_pkg;

    localparam int HDR_W        = 56;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 88;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [11:0] ADTS_SYNC = 12'hfff;
    localparam logic [2:0]  MIN_BYTES = 3'd7;

    // frame_length * sample_rate, before the scaling by 8 / 1024
    localparam int PROD_W      = 30;
    localparam int BR_W        = 23;
    localparam int SCALE_SHIFT = 7;
    localparam int SPF_W       = 13;
    localparam int BLOCK_SHIFT = 10;

    // floor(y / 3) = (y * ceil(2^25 / 3)) >> 25, exact for y below 2^24
    localparam int          RECIP_W     = 24;
    localparam logic [23:0] DIV3_MULT   = 24'haaaaab;
    localparam int          DIV3_SHIFT  = 25;
    localparam int          Q3_W        = BR_W + RECIP_W;

    typedef struct packed {
        logic        valid;
        logic        mpeg_id;
        logic [1:0]  layer_bits;
        logic [1:0]  profile_code;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
        logic [3:0]  channel_count;
        logic [16:0] sample_rate;
        logic [12:0] frame_length;
        logic [1:0]  raw_blocks;
    } hdr_t;

    function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
        logic [16:0] rate;
        unique case (idx)
            4'd0:    rate = 17'd96000;
            4'd1:    rate = 17'd88200;
            4'd2:    rate = 17'd64000;
            4'd3:    rate = 17'd48000;
            4'd4:    rate = 17'd44100;
            4'd5:    rate = 17'd32000;
            4'd6:    rate = 17'd24000;
            4'd7:    rate = 17'd22050;
            4'd8:    rate = 17'd16000;
            4'd9:    rate = 17'd12000;
            4'd10:   rate = 17'd11025;
            4'd11:   rate = 17'd8000;
            4'd12:   rate = 17'd7350;
            default: rate = 17'd0;
        endcase
        return rate;
    endfunction

    function automatic logic [3:0] chan_lookup(input logic [2:0] cfg);
        logic [3:0] chans;
        unique case (cfg)
            3'd7:    chans = 4'd8;
            default: chans = {1'b0, cfg};
        endcase
        return chans;
    endfunction

endpackage

// ===== rtl/core/ahd_front.sv =====
module ahd_front
    import ahd_pkg::*;
(
    input  logic [IN_DATA_W-1:0] tdata,
    output hdr_t                 hdr
);

    logic [HDR_W-1:0] bytes_in;
    logic [2:0]       byte_count;
    logic [16:0]      rate;
    logic [3:0]       chans;
    logic             ok;

    assign bytes_in   = tdata[HDR_W-1:0];
    assign byte_count = tdata[HDR_W+2:HDR_W];
    assign rate       = rate_lookup(bytes_in[37:34]);
    assign chans      = chan_lookup(bytes_in[32:30]);

    assign ok = (byte_count >= MIN_BYTES) && (bytes_in[55:44] == ADTS_SYNC)
             && (rate != 17'd0) && (chans != 4'd0);

    // zero every field of a rejected header
    always_comb
    begin
        hdr = '0;
        if (ok)
        begin
            hdr.valid          = 1'b1;
            hdr.mpeg_id        = bytes_in[43];
            hdr.layer_bits     = bytes_in[42:41];
            hdr.profile_code   = bytes_in[39:38];
            hdr.rate_index     = bytes_in[37:34];
            hdr.channel_config = bytes_in[32:30];
            hdr.channel_count  = chans;
            hdr.sample_rate    = rate;
            hdr.frame_length   = bytes_in[25:13];
            hdr.raw_blocks     = bytes_in[1:0];
        end
    end

endmodule

// ===== rtl/core/ahd_queue.sv =====
module ahd_queue
    import ahd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  hdr_t push_data,
    output logic ready,
    input  logic pop,
    output hdr_t pop_data,
    output logic not_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hdr_t             store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more entries than its depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");

endmodule

// ===== rtl/core/ahd_back.sv =====
module ahd_back
    import ahd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  hdr_t                  q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    // stage A: frame_length * sample_rate
    logic              a_valid_reg;
    hdr_t              a_hdr_reg;
    logic [PROD_W-1:0] a_prod_reg, a_prod_next;

    // stage B: scaled product and its multiple by the reciprocal of three
    logic              b_valid_reg;
    hdr_t              b_hdr_reg;
    logic [BR_W-1:0]   b_y_reg, b_y_next;
    logic [Q3_W-1:0]   b_q3_reg, b_q3_next;

    // output register
    logic              o_valid_reg;
    hdr_t              o_hdr_reg;
    logic [SPF_W-1:0]  o_spf_reg, o_spf_next;
    logic [BR_W-1:0]   o_br_reg, o_br_next;

    logic out_load, b_load, a_load;

    assign out_load = b_valid_reg && (!o_valid_reg || m_tready);
    assign b_load   = a_valid_reg && (!b_valid_reg || out_load);
    assign a_load   = q_valid && (!a_valid_reg || b_load);
    assign q_pop    = a_load;

    assign a_prod_next = PROD_W'(q_data.frame_length) * PROD_W'(q_data.sample_rate);
    assign b_y_next    = a_prod_reg[PROD_W-1:SCALE_SHIFT];
    assign b_q3_next   = Q3_W'(b_y_next) * Q3_W'(DIV3_MULT);

    // divide by the number of raw blocks: one, two, three or four
    always_comb
    begin
        unique case (b_hdr_reg.raw_blocks)
            2'd0:    o_br_next = b_y_reg;
            2'd1:    o_br_next = b_y_reg >> 1;
            2'd2:    o_br_next = BR_W'(b_q3_reg[Q3_W-1:DIV3_SHIFT]);
            default: o_br_next = b_y_reg >> 2;
        endcase
        o_spf_next = '0;
        if (b_hdr_reg.valid)
            o_spf_next = {3'(b_hdr_reg.raw_blocks) + 3'd1, BLOCK_SHIFT'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (!a_valid_reg || b_load)
                a_valid_reg <= a_load;
            if (!b_valid_reg || out_load)
                b_valid_reg <= b_load;
            if (!o_valid_reg || m_tready)
                o_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_hdr_reg  <= q_data;
            a_prod_reg <= a_prod_next;
        end
        if (b_load)
        begin
            b_hdr_reg <= a_hdr_reg;
            b_y_reg   <= b_y_next;
            b_q3_reg  <= b_q3_next;
        end
        if (out_load)
        begin
            o_hdr_reg <= b_hdr_reg;
            o_spf_reg <= o_spf_next;
            o_br_reg  <= o_br_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_hdr_reg.valid;
    assign m_tdata  = {
        4'd0,
        o_br_reg,
        o_spf_reg,
        o_hdr_reg.raw_blocks,
        o_hdr_reg.frame_length,
        o_hdr_reg.sample_rate,
        o_hdr_reg.channel_count,
        o_hdr_reg.channel_config,
        o_hdr_reg.rate_index,
        o_hdr_reg.profile_code,
        o_hdr_reg.layer_bits,
        o_hdr_reg.mpeg_id
    };

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !o_hdr_reg.valid) |-> (o_br_reg == '0 && o_spf_reg == '0))
        else $error("rejected header carries a non-zero rate or frame size");

    a_spf_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && o_hdr_reg.valid)
            |-> (o_spf_reg[SPF_W-1:BLOCK_SHIFT] == 3'(o_hdr_reg.raw_blocks) + 3'd1))
        else $error("samples per frame disagree with raw block count");

    a_single_block: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_load) && $past(b_hdr_reg.raw_blocks) == 2'd0 |-> o_br_reg == $past(b_y_reg))
        else $error("single-block bit rate differs from scaled product");

    a_pop_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> a_valid_reg)
        else $error("popped header lost before the first stage");

endmodule

// ===== rtl/core/adts_header_decode.sv =====
// ADTS header decoder.
//
// Slave channel: s_tdata carries the first seven bytes of a candidate frame
// (byte zero in bits 55:48) and the number of bytes actually present.
// Master channel: one transaction per input transaction, in order. m_tuser
// is high when sync, rate index, channel configuration and length checks all
// pass; otherwise every field in m_tdata is zero.
//
// Between the input queue and m_tvalid a header passes through the
// two multiplier stages (frame_length * sample_rate, then the reciprocal
// multiply for three raw blocks) and the output register.
// Throughput: one header per cycle while m_tready stays high.
//
// Reset clears the input queue and all stage valid flags; no transaction
// is presented afterwards until a new one is accepted.
// When m_tready is low the pipeline closes its bubbles, then the input
// queue fills, and s_tready drops once it is full; nothing is dropped.
module adts_header_decode
    import ahd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // header_bytes[55:0], byte_count[58:56]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // mpeg_id[0], layer_bits[2:1],
                                            // profile_code[4:3], rate_index[8:5],
                                            // channel_config[11:9],
                                            // channel_count[15:12],
                                            // sample_rate[32:16],
                                            // frame_length[45:33], raw_blocks[47:46],
                                            // samples_per_frame[60:48],
                                            // bit_rate[83:61]
    output logic                  m_tuser   // header_valid[0]
);

    hdr_t front_hdr;
    hdr_t q_data;
    logic q_ready;
    logic q_valid;
    logic q_pop;

    assign s_tready = q_ready;

    ahd_front u_front (
        .tdata (s_tdata),
        .hdr   (front_hdr)
    );

    ahd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && q_ready),
        .push_data (front_hdr),
        .ready     (q_ready),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    ahd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== dv/adts_header_decode_test.sv =====
module adts_header_decode_test;
    import ahd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1050;

    localparam logic [16:0] RATE_HZ [16] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
        17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
        17'd7350, 17'd0, 17'd0, 17'd0
    };

    typedef struct packed {
        logic        valid;
        logic        mpeg_id;
        logic [1:0]  layer_bits;
        logic [1:0]  profile_code;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
        logic [3:0]  channel_count;
        logic [16:0] sample_rate;
        logic [12:0] frame_length;
        logic [1:0]  raw_blocks;
        logic [12:0] samples_per_frame;
        logic [22:0] bit_rate;
    } adts_fields_t;

    class adts_scoreboard;
        adts_fields_t expected_headers[$];
        int           errors;
        int           checked;
        int           valid_seen;

        function new();
            errors     = 0;
            checked    = 0;
            valid_seen = 0;
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction

        function adts_fields_t decode_adts(logic [55:0] hdr, logic [2:0] cnt);
            adts_fields_t f;
            logic [16:0]  rate;
            logic [3:0]   chans;
            logic [12:0]  spf;
            logic [63:0]  bits;
            f     = '0;
            rate  = RATE_HZ[hdr[37:34]];
            chans = (hdr[32:30] == 3'd7) ? 4'd8 : {1'b0, hdr[32:30]};
            if (cnt < MIN_BYTES || hdr[55:44] != ADTS_SYNC || rate == '0 || chans == '0)
                return f;
            spf  = 13'((32'(hdr[1:0]) + 32'd1) * 32'd1024);
            bits = (64'(hdr[25:13]) * 64'd8 * 64'(rate)) / 64'(spf);
            f.valid             = 1'b1;
            f.mpeg_id           = hdr[43];
            f.layer_bits        = hdr[42:41];
            f.profile_code      = hdr[39:38];
            f.rate_index        = hdr[37:34];
            f.channel_config    = hdr[32:30];
            f.channel_count     = chans;
            f.sample_rate       = rate;
            f.frame_length      = hdr[25:13];
            f.raw_blocks        = hdr[1:0];
            f.samples_per_frame = spf;
            f.bit_rate          = bits[22:0];
            return f;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at result %0d: %s", checked, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        function void note_header(logic [55:0] hdr, logic [2:0] cnt);
            expected_headers.push_back(decode_adts(hdr, cnt));
        endfunction

        task check_decode(logic [OUT_DATA_W-1:0] data, logic user);
            adts_fields_t want;
            if (expected_headers.size() == 0)
            begin
                report("result with no header outstanding");
                return;
            end
            want = expected_headers.pop_front();
            if (want.valid)
                valid_seen++;
            compare_field("header_valid", 32'(user), 32'(want.valid));
            compare_field("mpeg_id", 32'(data[0]), 32'(want.mpeg_id));
            compare_field("layer_bits", 32'(data[2:1]), 32'(want.layer_bits));
            compare_field("profile_code", 32'(data[4:3]), 32'(want.profile_code));
            compare_field("rate_index", 32'(data[8:5]), 32'(want.rate_index));
            compare_field("channel_config", 32'(data[11:9]), 32'(want.channel_config));
            compare_field("channel_count", 32'(data[15:12]), 32'(want.channel_count));
            compare_field("sample_rate", 32'(data[32:16]), 32'(want.sample_rate));
            compare_field("frame_length", 32'(data[45:33]), 32'(want.frame_length));
            compare_field("raw_blocks", 32'(data[47:46]), 32'(want.raw_blocks));
            compare_field("samples_per_frame", 32'(data[60:48]),
                          32'(want.samples_per_frame));
            compare_field("bit_rate", 32'(data[83:61]), 32'(want.bit_rate));
            compare_field("padding", 32'(data[87:84]), 32'd0);
            checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    adts_scoreboard sb;
    bit             no_gaps;
    int             cycle_count;
    int             sent;

    adts_header_decode i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        sb          = new();
        no_gaps     = 1'b0;
        cycle_count = 0;
        sent        = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("adts_header_decode_test failed");
            $finish;
        end
    end

    // Handshakes are sampled before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_decode(m_tdata, m_tuser);
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end

    function automatic logic [55:0] rand_bits56();
        return 56'({$urandom(), $urandom()} >> 8);
    endfunction

    // Random filler in the bits that the decoder ignores, then the fields.
    function automatic logic [55:0] build_header(logic [11:0] sync, logic id,
                                                 logic [1:0] layer, logic [1:0] profile,
                                                 logic [3:0] ridx, logic [2:0] ccfg,
                                                 logic [12:0] flen, logic [1:0] rdb,
                                                 logic [55:0] filler);
        logic [55:0] hdr;
        hdr        = filler;
        hdr[55:44] = sync;
        hdr[43]    = id;
        hdr[42:41] = layer;
        hdr[39:38] = profile;
        hdr[37:34] = ridx;
        hdr[32:30] = ccfg;
        hdr[25:13] = flen;
        hdr[1:0]   = rdb;
        return hdr;
    endfunction

    task automatic send_header(logic [55:0] hdr, logic [2:0] cnt);
        while (!no_gaps && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, cnt, hdr};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_header(hdr, cnt);
        sent++;
    endtask

    task automatic send_random_header();
        logic [55:0] hdr;
        logic [3:0]  ridx;
        logic [2:0]  ccfg;
        logic [11:0] sync;
        logic [2:0]  cnt;
        int          pick;
        pick = $urandom_range(0, 99);
        ridx = 4'($urandom_range(0, 12));
        ccfg = 3'($urandom_range(1, 7));
        sync = ADTS_SYNC;
        cnt  = MIN_BYTES;
        if (pick < 5)
            ridx = 4'($urandom_range(13, 15));
        else if (pick < 10)
            ccfg = 3'd0;
        else if (pick < 14)
            sync = ADTS_SYNC ^ (12'd1 << $urandom_range(0, 11));
        else if (pick < 18)
            cnt = 3'($urandom_range(0, 6));
        hdr = build_header(sync, 1'($urandom()), 2'($urandom()), 2'($urandom()), ridx,
                           ccfg, 13'($urandom()), 2'($urandom()), rand_bits56());
        // Pure noise, any count.
        if (pick >= 92)
        begin
            hdr = rand_bits56();
            cnt = 3'($urandom());
        end
        send_header(hdr, cnt);
    endtask

    initial
    begin
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and each rejection reason.
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd0, 4'd0, 3'd1, 13'd0, 2'd0,
                                 56'd0), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b1, 2'd3, 2'd3, 4'd12, 3'd7, 13'h1fff,
                                 2'd3, '1), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd1, 4'd0, 3'd7, 13'h1fff,
                                 2'd0, rand_bits56()), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd1, 4'd13, 3'd2, 13'd400,
                                 2'd0, rand_bits56()), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b1, 2'd0, 2'd1, 4'd14, 3'd2, 13'd400,
                                 2'd1, rand_bits56()), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd1, 4'd15, 3'd2, 13'd400,
                                 2'd2, rand_bits56()), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd1, 4'd3, 3'd0, 13'd400,
                                 2'd0, rand_bits56()), MIN_BYTES);
        send_header(build_header(12'hffe, 1'b0, 2'd0, 2'd1, 4'd3, 3'd2, 13'd400,
                                 2'd0, rand_bits56()), MIN_BYTES);
        send_header(build_header(12'h000, 1'b0, 2'd0, 2'd1, 4'd3, 3'd2, 13'd400,
                                 2'd0, rand_bits56()), MIN_BYTES);
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd1, 4'd4, 3'd2, 13'd400,
                                 2'd0, rand_bits56()), 3'd0);
        send_header(build_header(ADTS_SYNC, 1'b0, 2'd0, 2'd1, 4'd4, 3'd2, 13'd400,
                                 2'd0, rand_bits56()), 3'd6);
        send_header(56'd0, 3'd0);
        send_header('1, MIN_BYTES);
        for (i = 1; i <= 11; i++)
            send_header(build_header(ADTS_SYNC, 1'(i), 2'(i), 2'(i), 4'(i), 3'(i % 7 + 1),
                                     13'($urandom()), 2'(i), rand_bits56()), MIN_BYTES);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_gaps = (i >= 400 && i < 600);
            send_random_header();
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d headers sent, %0d results checked, %0d of them valid",
                 sent, sb.checked, sb.valid_seen);
        $display("%0d field mismatches", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("adts_header_decode_test passed");
        else
            $display("adts_header_decode_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ahd_pkg.sv
rtl/core/ahd_front.sv
rtl/core/ahd_queue.sv
rtl/core/ahd_back.sv
rtl/core/adts_header_decode.sv
dv/adts_header_decode_test.sv
